// ===== sv/c3lb_pkg.sv =====
package c3lb_pkg;

    // frame geometry and number format
    localparam int IMAGE_COLS    = 26;
    localparam int IMAGE_ROWS    = 26;
    localparam int FRACTION_BITS = 16;

    localparam int DATA_W     = 32;
    localparam int COEF_IDX_W = 4;
    localparam int NUM_TAPS   = 9;
    localparam int NUM_GROUPS = 3;
    localparam int COL_W      = $clog2(IMAGE_COLS);
    localparam int ROW_W      = $clog2(IMAGE_ROWS);
    localparam int LINE_W     = 2 * DATA_W;
    localparam int S_TDATA_W  = ((DATA_W + COEF_IDX_W + 7) / 8) * 8;

    // item kinds carried in tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_COEF  = 1'b1;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [NUM_TAPS-1:0][DATA_W-1:0] tap_vec_t;
    typedef logic [NUM_GROUPS-1:0][DATA_W-1:0] group_vec_t;

    // one accepted item on its way into the window stage
    typedef struct packed {
        logic                  is_pix;
        logic                  produce;
        logic                  last;
        logic [DATA_W-1:0]     value;
        logic [COEF_IDX_W-1:0] coef_index;
        logic [COL_W-1:0]      col;
    } c3lb_item_t;

    // signed product, floor shift by the fraction bits, low word kept
    function automatic word_t fixed_mul(input word_t a, input word_t b);
        logic signed [2*DATA_W-1:0] p;
        p = $signed(a) * $signed(b);
        return p[FRACTION_BITS +: DATA_W];
    endfunction

endpackage

// ===== sv/c3lb_ram.sv =====
module c3lb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== sv/c3lb_window.sv =====
module c3lb_window
    import c3lb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  c3lb_item_t in_item,
    output logic       prod_valid,
    input  logic       prod_ready,
    output tap_vec_t   prod_data,
    output logic       prod_last
);

    c3lb_item_t            item_reg;
    logic                  item_valid_reg;
    logic                  adv;
    logic [LINE_W-1:0]     line_rd;
    logic [LINE_W-1:0]     line_wr;
    word_t                 top_word;
    word_t                 mid_word;
    word_t                 win_reg [NUM_TAPS];
    word_t                 win_next [NUM_TAPS];
    word_t                 coef_reg [NUM_TAPS];
    tap_vec_t              prod_reg;
    logic                  prod_valid_reg;
    logic                  prod_valid_next;
    logic                  prod_last_reg;

    // stage handshake: the item stage moves when the product stage frees up
    assign adv      = item_valid_reg && (!prod_valid_reg || prod_ready);
    assign in_ready = !item_valid_reg || adv;

    // line store: each column entry holds {middle row, top row}
    c3lb_ram #(
        .WIDTH(LINE_W),
        .DEPTH(IMAGE_COLS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (adv && item_reg.is_pix),
        .wr_addr (item_reg.col),
        .wr_data (line_wr),
        .rd_en   (in_valid && in_ready && in_item.is_pix),
        .rd_addr (in_item.col),
        .rd_data (line_rd)
    );

    assign top_word = line_rd[DATA_W-1:0];
    assign mid_word = line_rd[LINE_W-1:DATA_W];
    assign line_wr  = {item_reg.value, mid_word};

    // item stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (in_ready) begin
            item_valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    // window shifted left by one column, new right column from the line store and the current pixel
    always_comb begin
        for (int k = 0; k < NUM_GROUPS; k++) begin
            win_next[k*3]     = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = top_word;
        win_next[5] = mid_word;
        win_next[8] = item_reg.value;
    end

    // window and coefficient updates, in item order
    always_ff @(posedge aclk) begin
        if (adv && item_reg.is_pix) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                coef_reg[k] <= '0;
            end
        end else if (adv && !item_reg.is_pix
                     && item_reg.coef_index < COEF_IDX_W'(NUM_TAPS)) begin
            coef_reg[item_reg.coef_index] <= item_reg.value;
        end
    end

    // nine parallel multipliers into the product register
    always_comb begin
        if (adv) begin
            prod_valid_next = item_reg.is_pix && item_reg.produce;
        end else if (prod_ready) begin
            prod_valid_next = 1'b0;
        end else begin
            prod_valid_next = prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
        end
        if (adv) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                prod_reg[k] <= fixed_mul(win_next[k], coef_reg[k]);
            end
            prod_last_reg <= item_reg.last;
        end
    end

    assign prod_valid = prod_valid_reg;
    assign prod_data  = prod_reg;
    assign prod_last  = prod_last_reg;

endmodule

// ===== sv/c3lb_adder.sv =====
module c3lb_adder
    import c3lb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     relu_en,
    input  logic     prod_valid,
    output logic     prod_ready,
    input  tap_vec_t prod_data,
    input  logic     prod_last,
    output logic     out_valid,
    input  logic     out_ready,
    output word_t    out_data,
    output logic     out_last
);

    group_vec_t psum_reg;
    logic       psum_valid_reg;
    logic       psum_last_reg;
    logic       psum_ready;
    logic       psum_adv;
    word_t      sum_next;
    word_t      out_data_reg;
    logic       out_valid_reg;
    logic       out_last_reg;

    assign psum_ready = !out_valid_reg || out_ready;
    assign psum_adv   = psum_valid_reg && psum_ready;
    assign prod_ready = !psum_valid_reg || psum_ready;

    // partial sums, one per kernel row, with wrap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psum_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            psum_valid_reg <= prod_valid;
        end
        if (prod_ready && prod_valid) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                psum_reg[g] <= prod_data[g*3] + prod_data[g*3 + 1] + prod_data[g*3 + 2];
            end
            psum_last_reg <= prod_last;
        end
    end

    // final sum and optional relu
    always_comb begin
        sum_next = psum_reg[0] + psum_reg[1] + psum_reg[2];
        if (relu_en && sum_next[DATA_W-1]) begin
            sum_next = '0;
        end
    end

    // output register, holds a result while the sink stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (psum_ready) begin
            out_valid_reg <= psum_valid_reg;
        end
        if (psum_adv) begin
            out_data_reg <= sum_next;
            out_last_reg <= psum_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/conv3x3_line_buffer_relu.sv =====
// Streaming 3x3 valid-region correlation over a raster-order frame of
// IMAGE_COLS x IMAGE_ROWS signed Q16.16 pixels. One beat is taken every clock
// cycle unless the output stalls, pixels and coefficient loads alike; a pixel
// whose window centre sits one pixel inside every edge yields one result via
// the item, product, partial-sum and output registers, and m_tlast marks the
// frame's bottom-right result. The rate is set by the line-store memory, which
// is read once per pixel when the beat is taken and written back at the same
// column when the item leaves the item stage; the nine multipliers work in
// parallel behind it, and a partial-sum stage and a final-sum output register
// follow. Coefficient beats (tuser = 1) write the tap named by coef_index and
// produce no result. The user must write relu_enable only while the block is
// idle (not enforced); the line store needs no clearing pass after reset.
module conv3x3_line_buffer_relu
    import c3lb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,   // relu_enable
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,       // value[31:0], coef_index[35:32]
    input  logic                 s_tuser,       // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,       // feature[31:0]
    output logic                 m_tlast
);

    logic             relu_en_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             acc_pix;
    logic             col_end;
    logic             row_end;
    c3lb_item_t       item;
    logic             prod_valid;
    logic             prod_ready;
    tap_vec_t         prod_data;
    logic             prod_last;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relu_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            relu_en_reg <= cfg_wr_data;
        end
    end

    assign acc_pix = s_tvalid && s_tready && (s_tuser == MODE_PIXEL);
    assign col_end = (col_reg == COL_W'(IMAGE_COLS - 1));
    assign row_end = (row_reg == ROW_W'(IMAGE_ROWS - 1));

    // raster position of the next pixel
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc_pix) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // tag the beat with its position flags
    always_comb begin
        item.is_pix     = (s_tuser == MODE_PIXEL);
        item.produce    = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        item.last       = row_end && col_end;
        item.value      = s_tdata[DATA_W-1:0];
        item.coef_index = s_tdata[DATA_W +: COEF_IDX_W];
        item.col        = col_reg;
    end

    c3lb_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (item),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_data  (prod_data),
        .prod_last  (prod_last)
    );

    c3lb_adder u_adder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .relu_en    (relu_en_reg),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_data  (prod_data),
        .prod_last  (prod_last),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

    // position counters stay inside the frame
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_W'(IMAGE_COLS - 1))
        else $error("column counter out of range");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_W'(IMAGE_ROWS - 1))
        else $error("row counter out of range");

    // the frame's last pixel returns the position to the origin
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_pix && col_end && row_end) |=> (col_reg == '0 && row_reg == '0))
        else $error("position did not wrap at frame end");

endmodule
